// ===== design/tcw_pkg.sv =====
// Package for the text console cell writer: screen geometry, field widths,
// request and register codes, FSM state type and controller/datapath structs.
// No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR = 1'b1;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_BS    = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

    localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h04;
    localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h07;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RWAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic copy_rd;
        logic copy_wr;
        logic fill;
        logic fill_init;
        logic load_bottom;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       needs_scroll;
        logic       sweep_last;
        logic       sweep_last_copy;
    } t_dp_status;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// Controller FSM of the text console cell writer.
// Depends on tcw_pkg for the state type, request codes and command/status structs.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd,
    output logic            busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (i_status.kind)
                    KIND_PUT:   n_state = i_status.needs_scroll ? ST_SCROLL_RD : ST_IDLE;
                    KIND_BS:    n_state = ST_IDLE;
                    KIND_CLEAR: n_state = ST_FILL;
                    KIND_READ:  n_state = ST_RWAIT;
                endcase
            end
            ST_RWAIT:     n_state = ST_IDLE;
            ST_SCROLL_RD: n_state = ST_SCROLL_WR;
            ST_SCROLL_WR: begin
                n_state = i_status.sweep_last_copy ? ST_FILL : ST_SCROLL_RD;
            end
            ST_FILL: begin
                if (i_status.sweep_last) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.fill      = 1'b1;
                o_cmd.fill_init = 1'b1;
            end
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ST_EXEC: begin
                o_cmd.exec   = 1'b1;
                o_cmd.finish = (i_status.kind == KIND_BS) ||
                               ((i_status.kind == KIND_PUT) && !i_status.needs_scroll);
            end
            ST_RWAIT: begin
                o_cmd.finish = 1'b1;
            end
            ST_SCROLL_RD: begin
                o_cmd.copy_rd = 1'b1;
            end
            ST_SCROLL_WR: begin
                o_cmd.copy_wr     = 1'b1;
                o_cmd.load_bottom = i_status.sweep_last_copy;
            end
            ST_FILL: begin
                o_cmd.fill   = 1'b1;
                o_cmd.finish = i_status.sweep_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
// Datapath of the text console cell writer: screen memory, cursor, attribute
// registers, sweep address counter and result registers. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctl_cmd             i_cmd,
    output t_dp_status                o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic [1:0]           i_kind,
    input  wire logic [CHAR_W-1:0]    i_char_code,
    input  wire logic [ROW_W-1:0]     i_read_row,
    input  wire logic [COL_W-1:0]     i_read_col,
    output logic                      o_done,
    output logic [COL_W-1:0]          o_cursor_col,
    output logic [ROW_W-1:0]          o_cursor_row,
    output logic [CHAR_W-1:0]         o_cell_char,
    output logic [ATTR_W-1:0]         o_cell_attr
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    logic [ATTR_W-1:0] r_text_attr;
    logic [ATTR_W-1:0] r_blank_attr;

    logic [1:0]        r_kind;
    logic [CHAR_W-1:0] r_char;
    logic [ROW_W-1:0]  r_read_row;
    logic [COL_W-1:0]  r_read_col;

    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [ADDR_W-1:0] r_sweep;

    logic              r_done;
    logic [CHAR_W-1:0] r_cell_char;
    logic [ATTR_W-1:0] r_cell_attr;

    logic              newline;
    logic              at_last_col;
    logic              at_last_row;
    logic              put_wrap;
    logic              origin;
    logic              read_ok;
    logic [COL_W-1:0]  bs_col;
    logic [ROW_W-1:0]  bs_row;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    always_comb begin
        newline     = (r_char == NEWLINE_CHAR);
        at_last_col = (r_cur_col == LAST_COL);
        at_last_row = (r_cur_row == LAST_ROW);
        put_wrap    = newline || at_last_col;
        origin      = (r_cur_col == '0) && (r_cur_row == '0);
        read_ok     = (r_read_row < ROW_W'(ROWS)) && (r_read_col < COL_W'(COLUMNS));
        if (r_cur_col == '0) begin
            bs_col = LAST_COL;
            bs_row = r_cur_row - ROW_W'(1);
        end else begin
            bs_col = r_cur_col - COL_W'(1);
            bs_row = r_cur_row;
        end
    end

    always_comb begin
        o_status.kind            = r_kind;
        o_status.needs_scroll    = put_wrap && at_last_row;
        o_status.sweep_last      = (r_sweep == LAST_CELL);
        o_status.sweep_last_copy = (r_sweep == LAST_COPY);
    end

    // Memory write and read port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = {i_cmd.fill_init ? BLANK_ATTR_RST : r_blank_attr, SPACE_CHAR};
        if (i_cmd.exec) begin
            if ((r_kind == KIND_PUT) && !newline) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(r_cur_row, r_cur_col);
                mem_wdata = {r_text_attr, r_char};
            end else if ((r_kind == KIND_BS) && !origin) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(bs_row, bs_col);
                mem_wdata = {r_text_attr, SPACE_CHAR};
            end
        end else if (i_cmd.copy_wr) begin
            mem_we    = 1'b1;
            mem_wdata = r_rd_data;
        end else if (i_cmd.fill) begin
            mem_we    = 1'b1;
        end
        mem_re    = i_cmd.copy_rd || (i_cmd.exec && (r_kind == KIND_READ) && read_ok);
        mem_raddr = i_cmd.copy_rd ? r_sweep + ADDR_W'(COLUMNS)
                                  : cell_addr(r_read_row, r_read_col);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr  <= TEXT_ATTR_RST;
            r_blank_attr <= BLANK_ATTR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEXT_ATTR:  r_text_attr  <= i_cfg_wdata;
                CFG_BLANK_ATTR: r_blank_attr <= i_cfg_wdata;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_char     <= i_char_code;
            r_read_row <= i_read_row;
            r_read_col <= i_read_col;
        end
    end

    // Cursor and sweep counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_sweep   <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_sweep <= '0;
                case (r_kind)
                    KIND_PUT: begin
                        if (put_wrap) begin
                            r_cur_col <= '0;
                            if (!at_last_row) r_cur_row <= r_cur_row + ROW_W'(1);
                        end else begin
                            r_cur_col <= r_cur_col + COL_W'(1);
                        end
                    end
                    KIND_BS: begin
                        if (!origin) begin
                            r_cur_col <= bs_col;
                            r_cur_row <= bs_row;
                        end
                    end
                    KIND_CLEAR: begin
                        r_cur_col <= '0;
                        r_cur_row <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.load_bottom) begin
                r_sweep <= BOTTOM_ROW;
            end else if (i_cmd.copy_wr || i_cmd.fill) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if ((r_kind == KIND_READ) && read_ok) begin
                r_cell_char <= r_rd_data[CHAR_W-1:0];
                r_cell_attr <= r_rd_data[CELL_W-1:CHAR_W];
            end else begin
                r_cell_char <= '0;
                r_cell_attr <= '0;
            end
        end
    end

    assign o_done       = r_done;
    assign o_cursor_col = r_cur_col;
    assign o_cursor_row = r_cur_row;
    assign o_cell_char  = r_cell_char;
    assign o_cell_attr  = r_cell_attr;

endmodule

`default_nettype wire

// ===== design/text_console_cell_writer_unit.sv =====
// Top level of the text console cell writer: joins the controller FSM and
// the datapath. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// A request is taken at a clock edge where start is high and busy is low, and
// exactly one result comes back on o_done, a one-cycle strobe that the
// receiver cannot hold off; the cursor and cell ports are valid in that cycle.
// The screen is a single 2000-entry memory with one write and one registered
// read per cycle. A put or backspace is captured in ST_IDLE and carried out in
// ST_EXEC, and a read cell request goes on from ST_EXEC to ST_RWAIT; o_done is
// registered from the final state. Clear writes every cell once. A put that
// runs past the last row scrolls: each of the 1920 cells of rows 1 to 24 is
// read in ST_SCROLL_RD and written back one row up in ST_SCROLL_WR, then the
// bottom row is blanked. After reset the block runs a clearing pass with busy
// high, writing a space with attribute 7 to every cell; register writes are
// taken during that pass. The next request can be taken in the same cycle as
// the strobe of the previous one. Registers (index 0 the text attribute,
// index 1 the blank attribute) are written whenever i_cfg_we is high, and
// should only change while the block is idle.
`default_nettype none

module text_console_cell_writer_unit
    import tcw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_kind,
    input  wire logic [CHAR_W-1:0]    i_char_code,
    input  wire logic [ROW_W-1:0]     i_read_row,
    input  wire logic [COL_W-1:0]     i_read_col,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                      o_done,
    output logic [COL_W-1:0]          o_cursor_col,
    output logic [ROW_W-1:0]          o_cursor_row,
    output logic [CHAR_W-1:0]         o_cell_char,
    output logic [ATTR_W-1:0]         o_cell_attr
);

    // Command and status between the FSM and the datapath.
    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (dp_status),
        .o_cmd    (ctl_cmd),
        .busy     (busy)
    );

    // The datapath owns the screen memory, cursor and result registers.
    tcw_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctl_cmd),
        .o_status     (dp_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_done       (o_done),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

endmodule

`default_nettype wire

// ===== design/tcw_checker.sv =====
// Port-level checker for the text console cell writer, bound to the top level.
// Depends on tcw_pkg and text_console_cell_writer_unit.
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire logic [COL_W-1:0]  o_cursor_col,
    input wire logic [ROW_W-1:0]  o_cursor_row
);

    // A taken request makes the block busy in the next cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a request was taken");

    // The result strobe comes only as the block goes idle.
    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // One strobe per request: never two in a row.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // The cursor is on the screen whenever a result is strobed.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_cursor_col < COL_W'(COLUMNS)) && (o_cursor_row < ROW_W'(ROWS))))
        else $error("cursor off the screen");

    // Without a request the cursor does not move.
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> ($stable(o_cursor_col) && $stable(o_cursor_row)))
        else $error("cursor moved while idle");

endmodule

bind text_console_cell_writer_unit tcw_checker u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_cursor_col (o_cursor_col),
    .o_cursor_row (o_cursor_row)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for text_console_cell_writer_unit: a directed table and
// random requests, checked against typed replies or a cycle-free console model.
// Depends on tcw_pkg and the RTL of the console cell writer.
module tb_top;
    import tcw_pkg::*;

    // Longest stretch without any accepted request or result before we give up.
    // A scroll and the clearing pass after reset are the slowest correct behavior,
    // and this limit leaves ample margin over both.
    localparam int QUIET_LIMIT = 20000;
    localparam int DIRECTED_ROWS = 23;

    // One result as the block reports it: the cursor plus the cell of a read.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } t_console_reply;

    // A directed request. When known is set, the reply is typed in by hand and
    // used as the expectation; otherwise the screen model supplies it.
    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
        logic              known;
        t_console_reply    reply;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_kind = KIND_PUT;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic [ROW_W-1:0]     i_read_row = '0;
    logic [COL_W-1:0]     i_read_col = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_TEXT_ATTR;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_done;
    logic [COL_W-1:0]     o_cursor_col;
    logic [ROW_W-1:0]     o_cursor_row;
    logic [CHAR_W-1:0]    o_cell_char;
    logic [ATTR_W-1:0]    o_cell_attr;

    // Model of the console: the screen, the cursor and both attribute registers.
    logic [CELL_W-1:0] screen_model [CELLS];
    logic [COL_W-1:0]  model_col;
    logic [ROW_W-1:0]  model_row;
    logic [ATTR_W-1:0] model_text_attr;
    logic [ATTR_W-1:0] model_blank_attr;

    t_console_reply pending_replies [$];
    int             mismatch_count = 0;
    int             requests_sent = 0;
    int             quiet_cycles = 0;
    int             sender_idle_pct = 0;

    // The directed part. Rows with typed replies run under the reset attributes
    // (text 4, blank 7), so the expected cells can be read off directly.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // A fresh screen holds spaces with the blank attribute.
        '{KIND_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{7'd0,  5'd0, SPACE_CHAR, BLANK_ATTR_RST}},
        // Backspace at the origin leaves everything as it is.
        '{KIND_BS,   8'h00, 5'd0,  7'd0,   1'b1, '{7'd0,  5'd0, 8'h00, 8'h00}},
        // Edge reads: off-screen ones return an empty cell; all bits set here.
        '{KIND_READ, 8'hFF, 5'd31, 7'd127, 1'b1, '{7'd0,  5'd0, 8'h00, 8'h00}},
        '{KIND_READ, 8'h00, 5'd24, 7'd79,  1'b1, '{7'd0,  5'd0, SPACE_CHAR, BLANK_ATTR_RST}},
        '{KIND_READ, 8'h00, 5'd25, 7'd0,   1'b1, '{7'd0,  5'd0, 8'h00, 8'h00}},
        '{KIND_READ, 8'h00, 5'd0,  7'd80,  1'b1, '{7'd0,  5'd0, 8'h00, 8'h00}},
        // Character extremes.
        '{KIND_PUT,  8'hFF, 5'd0,  7'd0,   1'b1, '{7'd1,  5'd0, 8'h00, 8'h00}},
        '{KIND_PUT,  8'h00, 5'd31, 7'd127, 1'b1, '{7'd2,  5'd0, 8'h00, 8'h00}},
        '{KIND_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{7'd2,  5'd0, 8'hFF, TEXT_ATTR_RST}},
        '{KIND_READ, 8'h00, 5'd0,  7'd1,   1'b1, '{7'd2,  5'd0, 8'h00, TEXT_ATTR_RST}},
        // Newline, then backspace across the row start to the last column.
        '{KIND_PUT,  NEWLINE_CHAR, 5'd0, 7'd0, 1'b1, '{7'd0, 5'd1, 8'h00, 8'h00}},
        '{KIND_BS,   8'h00, 5'd0,  7'd0,   1'b1, '{7'd79, 5'd0, 8'h00, 8'h00}},
        '{KIND_READ, 8'h00, 5'd0,  7'd79,  1'b1, '{7'd79, 5'd0, SPACE_CHAR, TEXT_ATTR_RST}},
        // A put in the last column wraps to the next row.
        '{KIND_PUT,  8'h41, 5'd0,  7'd0,   1'b1, '{7'd0,  5'd1, 8'h00, 8'h00}},
        '{KIND_READ, 8'h00, 5'd0,  7'd79,  1'b1, '{7'd0,  5'd1, 8'h41, TEXT_ATTR_RST}},
        '{KIND_BS,   8'h00, 5'd0,  7'd0,   1'b0, '0},
        '{KIND_READ, 8'h00, 5'd0,  7'd79,  1'b0, '0},
        '{KIND_PUT,  8'h7F, 5'd0,  7'd0,   1'b0, '0},
        '{KIND_PUT,  NEWLINE_CHAR, 5'd0, 7'd0, 1'b0, '0},
        // Clear homes the cursor and fills with the blank attribute.
        '{KIND_CLEAR, 8'h00, 5'd0, 7'd0,   1'b1, '{7'd0,  5'd0, 8'h00, 8'h00}},
        '{KIND_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{7'd0,  5'd0, SPACE_CHAR, BLANK_ATTR_RST}},
        '{KIND_READ, 8'h00, 5'd0,  7'd79,  1'b1, '{7'd0,  5'd0, SPACE_CHAR, BLANK_ATTR_RST}},
        '{KIND_READ, 8'h00, 5'd24, 7'd79,  1'b0, '0}
    };

    text_console_cell_writer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

    always #2 i_clk = ~i_clk;

    function automatic int cell_index(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        return int'(r) * COLUMNS + int'(c);
    endfunction

    function automatic void reset_console_model();
        model_text_attr  = TEXT_ATTR_RST;
        model_blank_attr = BLANK_ATTR_RST;
        model_col = '0;
        model_row = '0;
        for (int i = 0; i < CELLS; i++) screen_model[i] = {BLANK_ATTR_RST, SPACE_CHAR};
    endfunction

    // Apply one accepted request to the model and return the reply it calls for.
    function automatic t_console_reply update_console_model(logic [1:0] kind,
                                                            logic [CHAR_W-1:0] ch,
                                                            logic [ROW_W-1:0] rrow,
                                                            logic [COL_W-1:0] rcol);
        t_console_reply reply;
        reply = '0;
        case (kind)
            KIND_PUT: begin
                // A newline writes nothing; every other code lands at the cursor.
                if (ch == NEWLINE_CHAR) begin
                    model_col = '0;
                    model_row = model_row + ROW_W'(1);
                end else begin
                    screen_model[cell_index(model_row, model_col)] = {model_text_attr, ch};
                    model_col = model_col + COL_W'(1);
                end
                if (model_col >= COLUMNS) begin
                    model_col = '0;
                    model_row = model_row + ROW_W'(1);
                end
                // Running off the bottom scrolls everything up by one row.
                if (model_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_model[i] = {model_blank_attr, SPACE_CHAR};
                    model_col = '0;
                    model_row = LAST_ROW;
                end
            end
            KIND_BS: begin
                if (model_col != 0 || model_row != 0) begin
                    if (model_col == 0) begin
                        model_row = model_row - ROW_W'(1);
                        model_col = LAST_COL;
                    end else begin
                        model_col = model_col - COL_W'(1);
                    end
                    screen_model[cell_index(model_row, model_col)] =
                        {model_text_attr, SPACE_CHAR};
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = {model_blank_attr, SPACE_CHAR};
                model_col = '0;
                model_row = '0;
            end
            default: begin
                if (rrow < ROWS && rcol < COLUMNS)
                    {reply.attr, reply.ch} = screen_model[cell_index(rrow, rcol)];
            end
        endcase
        reply.col = model_col;
        reply.row = model_row;
        return reply;
    endfunction

    // Present one request and hold it until the block takes it. Start is left
    // high so that a following request can go out back to back.
    task automatic send_request(input logic [1:0] kind, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol,
                                input logic known, input t_console_reply typed_reply);
        t_console_reply predicted;
        start       <= 1'b1;
        i_kind      <= kind;
        i_char_code <= ch;
        i_read_row  <= rrow;
        i_read_col  <= rcol;
        do @(posedge i_clk); while (busy);
        predicted = update_console_model(kind, ch, rrow, rcol);
        pending_replies.push_back(known ? typed_reply : predicted);
        requests_sent++;
    endtask

    // A random request with the sender idling first at the current rate.
    task automatic issue(input logic [1:0] kind, input logic [CHAR_W-1:0] ch,
                         input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        send_request(kind, ch, rrow, rcol, 1'b0, '0);
    endtask

    // Hold off new requests until every outstanding reply has come back.
    task automatic wait_for_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // Change both attributes with the block idle. The short pause after the
    // last reply covers any tail of work behind the strobe.
    task automatic set_attributes(input logic [ATTR_W-1:0] text, input logic [ATTR_W-1:0] blank);
        wait_for_replies();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TEXT_ATTR;
        i_cfg_wdata <= text;
        @(posedge i_clk);
        model_text_attr = text;
        i_cfg_idx   <= CFG_BLANK_ATTR;
        i_cfg_wdata <= blank;
        @(posedge i_clk);
        model_blank_attr = blank;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic, mostly shaped as terminal output: lines of text, runs of
    // newlines that reach the bottom and scroll, full rows that wrap, reads of
    // freshly written cells and backspaces. A share of fully random requests,
    // out-of-range reads among them, and the odd clear are mixed in.
    task automatic run_random_phase(input int idle_pct, input int count);
        int target;
        int pick;
        int len;
        logic [COL_W-1:0] near_col;
        sender_idle_pct = idle_pct;
        target = requests_sent + count;
        while (requests_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                len = $urandom_range(1, 12);
                repeat (len) issue(KIND_PUT, 8'($urandom_range(255)),
                                   5'($urandom_range(31)), 7'($urandom_range(127)));
                if ($urandom_range(9) < 7)
                    issue(KIND_PUT, NEWLINE_CHAR, 5'($urandom_range(31)),
                          7'($urandom_range(127)));
            end else if (pick < 38) begin
                repeat ($urandom_range(1, 26))
                    issue(KIND_PUT, NEWLINE_CHAR, 5'($urandom_range(31)),
                          7'($urandom_range(127)));
            end else if (pick < 42) begin
                // Fill the rest of the row and spill over into the next one.
                len = COLUMNS - int'(model_col) + $urandom_range(0, 2);
                repeat (len) issue(KIND_PUT, 8'($urandom_range(255)), '0, '0);
            end else if (pick < 64) begin
                repeat ($urandom_range(1, 4)) begin
                    near_col = (model_col == 0) ? LAST_COL : model_col - COL_W'(1);
                    case ($urandom_range(3))
                        0: issue(KIND_READ, 8'($urandom_range(255)), model_row, near_col);
                        1: issue(KIND_READ, 8'($urandom_range(255)), LAST_ROW,
                                 7'($urandom_range(COLUMNS - 1)));
                        default: issue(KIND_READ, 8'($urandom_range(255)),
                                       5'($urandom_range(ROWS - 1)),
                                       7'($urandom_range(COLUMNS - 1)));
                    endcase
                end
            end else if (pick < 74) begin
                repeat ($urandom_range(1, 6))
                    issue(KIND_BS, 8'($urandom_range(255)), 5'($urandom_range(31)),
                          7'($urandom_range(127)));
            end else if (pick < 77) begin
                issue(KIND_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                      7'($urandom_range(127)));
            end else if (pick < 97) begin
                issue(2'($urandom_range(3)), 8'($urandom_range(255)),
                      5'($urandom_range(31)), 7'($urandom_range(127)));
            end else begin
                wait_for_replies();
            end
        end
    endtask

    // Count a failure; only the first ten are spelled out.
    function automatic void note_failure(string msg);
        if (mismatch_count < 10) $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endfunction

    // Every strobe is a result that must match the oldest outstanding request.
    always @(posedge i_clk) begin : reply_checker
        t_console_reply want;
        if (i_rst_n && o_done) begin
            if (pending_replies.size() == 0) begin
                note_failure("result strobe with no request outstanding");
            end else begin
                want = pending_replies.pop_front();
                check_field("cursor_col", int'(want.col), int'(o_cursor_col));
                check_field("cursor_row", int'(want.row), int'(o_cursor_row));
                check_field("cell_char", int'(want.ch), int'(o_cell_char));
                check_field("cell_attr", int'(want.attr), int'(o_cell_attr));
            end
        end
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        reset_console_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset attributes. The first one waits out
        // the clearing pass that follows reset.
        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].ch, directed_rows[i].rrow,
                         directed_rows[i].rcol, directed_rows[i].known,
                         directed_rows[i].reply);

        // Three random phases, each under its own attributes: a lightly idling
        // sender, a heavily idling one, then requests back to back.
        set_attributes(8'h00, 8'hFF);
        run_random_phase(18, 130);
        set_attributes(8'hFF, 8'h00);
        run_random_phase(76, 130);
        set_attributes(8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random_phase(0, 130);

        wait_for_replies();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_cell_writer_unit.sv
design/tcw_checker.sv
test/tb_top.sv
